// File: rtl/assert_macros.svh
// Assertion helper macros used by the top-level RTL file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, disabled while the active-low reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/tgmc_pkg.sv
// Shared types and constants of the tilt gesture mode controller.
// Depends on nothing; used by tgmc_classify, the top level and the testbench.
`default_nettype none

package tgmc_pkg;

    // Tilt directions, checked in priority order X, Y, Z
    typedef enum logic [2:0] {
        DIR_NONE = 3'd0,
        DIR_XUP  = 3'd1,
        DIR_XDN  = 3'd2,
        DIR_YUP  = 3'd3,
        DIR_YDN  = 3'd4,
        DIR_ZUP  = 3'd5,
        DIR_ZDN  = 3'd6
    } dir_t;

    // Command kinds on the result channel
    typedef enum logic [1:0] {
        KIND_FILTER_ON  = 2'd0,
        KIND_FILTER_OFF = 2'd1,
        KIND_HEATER     = 2'd2
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_TILT_THRESHOLD = 2'd0,
        REG_WAIT_TICKS     = 2'd1,
        REG_FILTER_DUR     = 2'd2,
        REG_MINUTE_MS      = 2'd3
    } cfg_index_t;

    // Input operation codes
    localparam logic OP_EVAL = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Register reset values
    localparam logic [14:0] TILT_THRESHOLD_RST = 15'd6000;
    localparam logic [15:0] WAIT_TICKS_RST     = 16'd400;
    localparam logic [31:0] FILTER_DUR_RST     = 32'd3600000;
    localparam logic [15:0] MINUTE_MS_RST      = 16'd60000;

    localparam logic [15:0] MINUTE_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// File: rtl/tgmc_classify.sv
// Sample classifier: maps one accelerometer sample to a tilt direction.
// Depends on tgmc_pkg for the direction type.
`default_nettype none

module tgmc_classify
    import tgmc_pkg::*;
(
    input  wire logic signed [15:0] accel_x,
    input  wire logic signed [15:0] accel_y,
    input  wire logic signed [15:0] accel_z,
    input  wire logic        [14:0] threshold,
    output dir_t                    dir
);

    logic signed [16:0] thr_pos;
    logic signed [16:0] thr_neg;
    logic signed [16:0] x_ext;
    logic signed [16:0] y_ext;
    logic signed [16:0] z_ext;

    // Widen everything to 17 bits so both bounds fit
    assign thr_pos = $signed({2'b00, threshold});
    assign thr_neg = -thr_pos;
    assign x_ext   = 17'(accel_x);
    assign y_ext   = 17'(accel_y);
    assign z_ext   = 17'(accel_z);

    // Pick the first tilted axis, X before Y before Z
    always_comb begin
        if (x_ext > thr_pos) begin
            dir = DIR_XUP;
        end else if (x_ext < thr_neg) begin
            dir = DIR_XDN;
        end else if (y_ext > thr_pos) begin
            dir = DIR_YUP;
        end else if (y_ext < thr_neg) begin
            dir = DIR_YDN;
        end else if (z_ext > thr_pos) begin
            dir = DIR_ZUP;
        end else if (z_ext < thr_neg) begin
            dir = DIR_ZDN;
        end else begin
            dir = DIR_NONE;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tilt_gesture_mode_controller.sv
// Tilt gesture mode controller: top level with mode machine and command output.
// Depends on tgmc_pkg, tgmc_classify and assert_macros.svh.
//
// Usage:
//   The s_ channel carries one item per transfer: tuser is the operation
//   (0 evaluate the sample in tdata, 1 one millisecond tick). An evaluation
//   steps the mode machine; entering a mode emits at most one command on
//   the m_ channel (tuser kind, tdata duration in ms). Ticks count down the
//   heater wait timer and emit nothing.
//   An accepted item is held in the input register; once the output
//   register is free, its command is loaded into the output register and
//   m_tvalid rises. Throughput: one item per cycle while the output register
//   frees, set by the single-pass next-state logic between the registers.
//   When the receiver stalls, the result stays in the output register and
//   s_tready stays high until the input register is also occupied.
//   The cfg port writes one register per cycle with cfg_we high; write it
//   only while no transfer is pending.
//   Reset (aresetn low, synchronous) loads the default register values,
//   puts the mode machine in its initial mode, clears the minute count and
//   wait timer, and empties both registers.
`default_nettype none
`include "assert_macros.svh"

module tilt_gesture_mode_controller
    import tgmc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
    input  wire logic        s_tuser,   // [0] operation
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] duration_ms
    output logic [1:0]       m_tuser,   // [1:0] message_kind
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    typedef enum logic [2:0] {
        MODE_INIT        = 3'd0,
        MODE_CHOOSE      = 3'd1,
        MODE_FILTER_ON   = 3'd2,
        MODE_FILTER_OFF  = 3'd3,
        MODE_HEATER_SET  = 3'd4,
        MODE_HEATER_OFF  = 3'd5,
        MODE_HEATER_WAIT = 3'd6,
        MODE_IDLE        = 3'd7
    } mode_t;

    // Configuration registers
    logic [14:0] tilt_threshold_reg;
    logic [15:0] wait_ticks_reg;
    logic [31:0] filter_dur_reg;
    logic [15:0] minute_ms_reg;

    // Input register
    logic        in_valid_reg;
    logic        in_op_reg;
    logic [47:0] in_data_reg;

    // Mode machine state
    mode_t       mode_reg,      mode_next;
    mode_t       prev_mode_reg, prev_mode_next;
    logic [15:0] minute_count_reg, minute_count_next;
    logic [15:0] wait_timer_reg,   wait_timer_next;

    // Output register
    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [31:0] m_dur_reg;

    logic        out_free;
    logic        advance;
    logic        entry;
    dir_t        dir;
    logic        emit;
    kind_t       kind_next;
    logic [31:0] dur_next;
    logic [15:0] minute_inc;
    logic [31:0] heater_ms;
    logic [15:0] timer_eff;

    // Handshake: the output register frees when empty or taken
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = m_dur_reg;

    tgmc_classify u_classify (
        .accel_x   ($signed(in_data_reg[15:0])),
        .accel_y   ($signed(in_data_reg[31:16])),
        .accel_z   ($signed(in_data_reg[47:32])),
        .threshold (tilt_threshold_reg),
        .dir       (dir)
    );

    assign entry      = (mode_reg != prev_mode_reg);
    assign minute_inc = (minute_count_reg != MINUTE_MAX) ? minute_count_reg + 16'd1
                                                         : minute_count_reg;
    assign heater_ms  = {16'd0, minute_inc} * {16'd0, minute_ms_reg};
    assign timer_eff  = entry ? wait_ticks_reg : wait_timer_reg;

    // Next state and command for the item in the input register
    always_comb begin
        mode_next         = mode_reg;
        prev_mode_next    = prev_mode_reg;
        minute_count_next = minute_count_reg;
        wait_timer_next   = wait_timer_reg;
        emit              = 1'b0;
        kind_next         = KIND_FILTER_ON;
        dur_next          = filter_dur_reg;
        if (in_op_reg == OP_TICK) begin
            if (wait_timer_reg != 16'd0) begin
                wait_timer_next = wait_timer_reg - 16'd1;
            end
        end else begin
            prev_mode_next = mode_reg;
            case (mode_reg)
                MODE_INIT: begin
                    minute_count_next = 16'd0;
                    mode_next         = MODE_CHOOSE;
                end
                MODE_CHOOSE: begin
                    if (dir == DIR_YUP) begin
                        mode_next = MODE_FILTER_ON;
                    end else if (dir == DIR_YDN) begin
                        mode_next = MODE_FILTER_OFF;
                    end else if (dir == DIR_XUP) begin
                        mode_next = MODE_HEATER_SET;
                    end else if (dir == DIR_XDN) begin
                        mode_next = MODE_HEATER_OFF;
                    end
                end
                MODE_FILTER_ON: begin
                    emit      = entry;
                    kind_next = KIND_FILTER_ON;
                    if (dir == DIR_YDN) begin
                        mode_next = MODE_FILTER_OFF;
                    end
                end
                MODE_FILTER_OFF: begin
                    emit      = entry;
                    kind_next = KIND_FILTER_OFF;
                    if (dir == DIR_YUP) begin
                        mode_next = MODE_FILTER_ON;
                    end
                end
                MODE_HEATER_SET: begin
                    if (entry) begin
                        minute_count_next = minute_inc;
                        emit              = 1'b1;
                    end
                    kind_next = KIND_HEATER;
                    dur_next  = heater_ms;
                    if (dir != DIR_XUP) begin
                        mode_next = MODE_HEATER_WAIT;
                    end
                end
                MODE_HEATER_OFF: begin
                    if (entry) begin
                        minute_count_next = 16'd0;
                        emit              = 1'b1;
                    end
                    kind_next = KIND_HEATER;
                    dur_next  = 32'd0;
                    if (dir != DIR_XDN) begin
                        mode_next = MODE_HEATER_WAIT;
                    end
                end
                MODE_HEATER_WAIT: begin
                    wait_timer_next = timer_eff;
                    if (timer_eff == 16'd0) begin
                        if (dir == DIR_XUP) begin
                            mode_next = MODE_HEATER_SET;
                        end else if (dir == DIR_XDN) begin
                            mode_next = MODE_HEATER_OFF;
                        end
                    end
                end
                default: begin
                    // Unreachable idle mode: hold and stay silent
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tilt_threshold_reg <= TILT_THRESHOLD_RST;
            wait_ticks_reg     <= WAIT_TICKS_RST;
            filter_dur_reg     <= FILTER_DUR_RST;
            minute_ms_reg      <= MINUTE_MS_RST;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_TILT_THRESHOLD: tilt_threshold_reg <= cfg_wdata[14:0];
                REG_WAIT_TICKS:     wait_ticks_reg     <= cfg_wdata[15:0];
                REG_FILTER_DUR:     filter_dur_reg     <= cfg_wdata;
                REG_MINUTE_MS:      minute_ms_reg      <= cfg_wdata[15:0];
                default: begin
                    tilt_threshold_reg <= tilt_threshold_reg;
                end
            endcase
        end
    end

    // Input register: load on transfer, drop once processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    // Mode machine state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_INIT;
            prev_mode_reg    <= MODE_INIT;
            minute_count_reg <= 16'd0;
            wait_timer_reg   <= 16'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (advance) begin
                mode_reg         <= mode_next;
                prev_mode_reg    <= prev_mode_next;
                minute_count_reg <= minute_count_next;
                wait_timer_reg   <= wait_timer_next;
            end
            if (out_free) begin
                m_valid_reg <= advance && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            m_kind_reg <= kind_next;
            m_dur_reg  <= dur_next;
        end
    end

    // Checks
    `ASSERT_IMPL(a_result_from_item, aclk, aresetn, $rose(m_valid_reg), $past(advance), "result without a processed item")
    `ASSERT_IMPL(a_minute_stable, aclk, aresetn, !$past(advance), $stable(minute_count_reg), "minute count moved without an item")
    `ASSERT_IMPL(a_prev_mode_track, aclk, aresetn, $past(advance && (in_op_reg == OP_EVAL)), prev_mode_reg == $past(mode_reg), "previous mode not tracking")
    `ASSERT_IMPL(a_filter_duration, aclk, aresetn, m_valid_reg && (m_kind_reg != KIND_HEATER), m_dur_reg == filter_dur_reg, "filter command duration mismatch")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the tilt gesture mode controller.
// Drives the s_ stream and cfg port, predicts commands, and checks the m_ stream.
// Depends on tgmc_pkg and the tilt_gesture_mode_controller RTL.
`default_nettype none

module tb_top;
    import tgmc_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int IDLE_CYCLES    = 6;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int MAX_PRINTS     = 50;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int MINUTE_STEPS   = 24;

    // Modes of the gesture machine, as the predictor tracks them
    typedef enum logic [2:0] {
        MODE_INIT        = 3'd0,
        MODE_CHOOSE      = 3'd1,
        MODE_FILTER_ON   = 3'd2,
        MODE_FILTER_OFF  = 3'd3,
        MODE_HEATER_SET  = 3'd4,
        MODE_HEATER_OFF  = 3'd5,
        MODE_HEATER_WAIT = 3'd6,
        MODE_IDLE        = 3'd7
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] duration_ms;
    } command_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;   // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
    logic        s_tuser   = 1'b0; // [0] operation
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [31:0] duration_ms
    logic [1:0]  m_tuser;          // [1:0] message_kind
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    // Predictor state and its copy of the registers
    mode_t       cur_mode;
    mode_t       last_mode;
    logic [15:0] minute_count;
    logic [15:0] wait_timer;
    logic [14:0] cfg_threshold;
    logic [15:0] cfg_wait_ticks;
    logic [31:0] cfg_filter_ms;
    logic [15:0] cfg_minute_ms;

    command_t    pending_commands[$];
    int          error_count      = 0;
    int          sender_idle_pct  = 0;
    int          receiver_idle_pct = 0;
    int          hold_requests    = 0;
    int          holds_served     = 0;
    int          hold_left        = 0;
    bit          heater_branch;

    tilt_gesture_mode_controller uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Print one line per mismatch (up to a cap) and count all of them
    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic queue_command(input kind_t kind, input logic [31:0] duration);
        command_t cmd;
        cmd.kind        = kind;
        cmd.duration_ms = duration;
        pending_commands.push_back(cmd);
    endtask

    function automatic logic [47:0] pack_sample(input int x, input int y, input int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    // Classify by priority X, Y, Z against the signed threshold
    function automatic dir_t classify_tilt(input logic [47:0] accel);
        int thr;
        int x;
        int y;
        int z;
        thr = int'(cfg_threshold);
        x = int'($signed(accel[15:0]));
        y = int'($signed(accel[31:16]));
        z = int'($signed(accel[47:32]));
        if (x > thr)  return DIR_XUP;
        if (x < -thr) return DIR_XDN;
        if (y > thr)  return DIR_YUP;
        if (y < -thr) return DIR_YDN;
        if (z > thr)  return DIR_ZUP;
        if (z < -thr) return DIR_ZDN;
        return DIR_NONE;
    endfunction

    task automatic reset_mode_model();
        cur_mode       = MODE_INIT;
        last_mode      = MODE_INIT;
        minute_count   = '0;
        wait_timer     = '0;
        cfg_threshold  = TILT_THRESHOLD_RST;
        cfg_wait_ticks = WAIT_TICKS_RST;
        cfg_filter_ms  = FILTER_DUR_RST;
        cfg_minute_ms  = MINUTE_MS_RST;
    endtask

    // Advance the mode machine by one accepted item and queue any command
    task automatic advance_mode_model(input logic op, input logic [47:0] accel);
        logic        entry;
        dir_t        dir;
        logic [31:0] heater_ms;
        if (op == OP_TICK) begin
            if (wait_timer != 0) wait_timer--;
            return;
        end
        entry     = (cur_mode != last_mode);
        last_mode = cur_mode;
        dir       = classify_tilt(accel);
        case (cur_mode)
            MODE_INIT: begin
                minute_count = '0;
                cur_mode     = MODE_CHOOSE;
            end
            MODE_CHOOSE: begin
                if (dir == DIR_YUP)      cur_mode = MODE_FILTER_ON;
                else if (dir == DIR_YDN) cur_mode = MODE_FILTER_OFF;
                else if (dir == DIR_XUP) cur_mode = MODE_HEATER_SET;
                else if (dir == DIR_XDN) cur_mode = MODE_HEATER_OFF;
            end
            MODE_FILTER_ON: begin
                if (entry) queue_command(KIND_FILTER_ON, cfg_filter_ms);
                if (dir == DIR_YDN) cur_mode = MODE_FILTER_OFF;
            end
            MODE_FILTER_OFF: begin
                if (entry) queue_command(KIND_FILTER_OFF, cfg_filter_ms);
                if (dir == DIR_YUP) cur_mode = MODE_FILTER_ON;
            end
            MODE_HEATER_SET: begin
                if (entry) begin
                    if (minute_count != MINUTE_MAX) minute_count++;
                    heater_ms = {16'd0, minute_count} * {16'd0, cfg_minute_ms};
                    queue_command(KIND_HEATER, heater_ms);
                end
                if (dir != DIR_XUP) cur_mode = MODE_HEATER_WAIT;
            end
            MODE_HEATER_OFF: begin
                if (entry) begin
                    queue_command(KIND_HEATER, 32'd0);
                    minute_count = '0;
                end
                if (dir != DIR_XDN) cur_mode = MODE_HEATER_WAIT;
            end
            MODE_HEATER_WAIT: begin
                if (entry) wait_timer = cfg_wait_ticks;
                if (wait_timer == 0) begin
                    if (dir == DIR_XUP)      cur_mode = MODE_HEATER_SET;
                    else if (dir == DIR_XDN) cur_mode = MODE_HEATER_OFF;
                end
            end
            default: ;
        endcase
    endtask

    // Offer one item, hold it until the transfer, then maybe drop valid for a random gap
    task automatic send_item(input logic op, input logic [47:0] accel);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= accel;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_mode_model(op, accel);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every command is out and the pipe has settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_commands.size() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    // Write all four registers back to back while the block is idle
    task automatic configure(input logic [14:0] thr, input logic [15:0] wticks,
                             input logic [31:0] dur, input logic [15:0] mins);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_TILT_THRESHOLD;
        cfg_wdata <= {17'd0, thr};
        @(posedge aclk);
        cfg_index <= REG_WAIT_TICKS;
        cfg_wdata <= {16'd0, wticks};
        @(posedge aclk);
        cfg_index <= REG_FILTER_DUR;
        cfg_wdata <= dur;
        @(posedge aclk);
        cfg_index <= REG_MINUTE_MS;
        cfg_wdata <= {16'd0, mins};
        @(posedge aclk);
        cfg_we         <= 1'b0;
        cfg_threshold  = thr;
        cfg_wait_ticks = wticks;
        cfg_filter_ms  = dur;
        cfg_minute_ms  = mins;
    endtask

    function automatic int high_axis(input int thr);
        if (thr >= 32767) return 32767;
        return $urandom_range(32767, thr + 1);
    endfunction

    function automatic int low_axis(input int thr);
        return -int'($urandom_range(32768, thr + 1));
    endfunction

    function automatic int calm_axis(input int thr);
        return int'($urandom_range(2 * thr, 0)) - thr;
    endfunction

    // Build a sample that classifies as the given direction: higher-priority axes calm, lower ones random
    function automatic logic [47:0] pick_sample(input dir_t dir);
        int thr;
        thr = int'(cfg_threshold);
        case (dir)
            DIR_XUP: return pack_sample(high_axis(thr), $urandom, $urandom);
            DIR_XDN: return pack_sample(low_axis(thr), $urandom, $urandom);
            DIR_YUP: return pack_sample(calm_axis(thr), high_axis(thr), $urandom);
            DIR_YDN: return pack_sample(calm_axis(thr), low_axis(thr), $urandom);
            DIR_ZUP: return pack_sample(calm_axis(thr), calm_axis(thr), high_axis(thr));
            DIR_ZDN: return pack_sample(calm_axis(thr), calm_axis(thr), low_axis(thr));
            default: return pack_sample(calm_axis(thr), calm_axis(thr), calm_axis(thr));
        endcase
    endfunction

    // Mostly gesture samples aimed at a direction, plus ticks and raw noise
    task automatic send_random_item();
        int   roll;
        dir_t dir;
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
            send_item(OP_TICK, 48'({$urandom, $urandom}));
        end else if (roll < 35) begin
            send_item(OP_EVAL, 48'({$urandom, $urandom}));
        end else begin
            case ($urandom_range(0, 9))
                0, 1:    dir = DIR_XUP;
                2, 3:    dir = DIR_XDN;
                4, 5:    dir = DIR_YUP;
                6, 7:    dir = DIR_YDN;
                8:       dir = DIR_NONE;
                default: dir = $urandom_range(0, 1) ? DIR_ZUP : DIR_ZDN;
            endcase
            send_item(OP_EVAL, pick_sample(dir));
        end
    endtask

    task automatic apply_reset();
        reset_mode_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    endtask

    // Leave INIT, then show that ticks, Z tilts and exact-threshold samples keep CHOOSE
    task automatic test_choose_mode();
        send_item(OP_EVAL, pack_sample(0, 0, 0));
        send_item(OP_TICK, pack_sample(0, 0, 0));
        send_item(OP_EVAL, pack_sample(0, 0, 32767));
        send_item(OP_EVAL, pack_sample(0, 0, -32768));
        send_item(OP_EVAL, pack_sample(6000, -6000, 6000));
        send_item(OP_EVAL, pack_sample(-6000, 6000, -6001));
    endtask

    // Toggle the filter pump; X tilts must lose to nothing here and change no mode
    task automatic test_filter_gestures();
        send_item(OP_EVAL, pack_sample(6000, 6001, 0));
        send_item(OP_EVAL, pack_sample(0, -32768, 0));
        send_item(OP_EVAL, pack_sample(0, 32767, 0));
        send_item(OP_EVAL, pack_sample(0, 0, 0));
        send_item(OP_EVAL, pack_sample(32767, -32768, 0));
        send_item(OP_EVAL, pack_sample(0, -6001, 0));
        send_item(OP_EVAL, pack_sample(0, -6001, 0));
        send_item(OP_TICK, pack_sample(-1, -1, -1));
        send_item(OP_EVAL, pack_sample(-32768, 32767, 0));
        send_item(OP_EVAL, pack_sample(0, 6001, 0));
        send_item(OP_EVAL, pack_sample(0, 0, 0));
    endtask

    // Heater set/off, wait timer countdown, timer held at zero, and a zero wait
    task automatic test_heater_gestures();
        configure(cfg_threshold, 16'd3, cfg_filter_ms, cfg_minute_ms);
        send_item(OP_EVAL, pack_sample(32767, -32768, 0));
        send_item(OP_EVAL, pack_sample(32767, 0, 0));
        send_item(OP_EVAL, pack_sample(6001, 0, 0));
        send_item(OP_EVAL, pack_sample(0, 0, 0));
        send_item(OP_EVAL, pack_sample(32767, 0, 0));
        send_item(OP_TICK, pack_sample(0, 0, 0));
        send_item(OP_TICK, pack_sample(0, 0, 0));
        send_item(OP_EVAL, pack_sample(-32768, 0, 0));
        send_item(OP_TICK, pack_sample(0, 0, 0));
        send_item(OP_TICK, pack_sample(0, 0, 0));
        send_item(OP_EVAL, pack_sample(-6001, 32767, 0));
        send_item(OP_EVAL, pack_sample(-32768, 0, 0));
        send_item(OP_EVAL, pack_sample(0, 0, 32767));
        send_item(OP_EVAL, pack_sample(0, 0, 0));
        repeat (3) send_item(OP_TICK, pack_sample(0, 0, 0));
        configure(cfg_threshold, 16'd0, cfg_filter_ms, cfg_minute_ms);
        send_item(OP_EVAL, pack_sample(32767, 0, 0));
        send_item(OP_EVAL, pack_sample(0, 0, 0));
        send_item(OP_EVAL, pack_sample(32767, 0, 0));
        send_item(OP_EVAL, pack_sample(0, 0, 0));
    endtask

    task automatic test_random_gestures(input int n_items);
        repeat (n_items) send_random_item();
    endtask

    // Hold the receiver off for a long stretch while items keep coming
    task automatic test_receiver_backpressure();
        configure(15'($urandom_range(2000, 12000)), 16'd0, $urandom,
                  16'($urandom_range(1, 65535)));
        hold_requests++;
        repeat (150) send_random_item();
    endtask

    // Step the minute count up repeatedly at the largest minute length
    task automatic test_minute_saturation();
        configure(cfg_threshold, 16'd0, cfg_filter_ms, 16'hFFFF);
        // settle in the wait mode with the entry taken and the timer cleared
        while (cur_mode != MODE_HEATER_WAIT || last_mode != cur_mode || wait_timer != 0) begin
            if (cur_mode == MODE_HEATER_WAIT && last_mode == cur_mode) begin
                send_item(OP_TICK, pack_sample(0, 0, 0));
            end else begin
                send_item(OP_EVAL, pack_sample(0, 0, 0));
            end
        end
        repeat (MINUTE_STEPS) begin
            send_item(OP_EVAL, pick_sample(DIR_XUP));
            send_item(OP_EVAL, pick_sample(DIR_NONE));
        end
    endtask

    // Compare each command transfer with the oldest prediction
    task automatic check_command();
        command_t want;
        if (pending_commands.size() == 0) begin
            report_mismatch($sformatf("unexpected command kind %0d duration %0d",
                                      m_tuser, m_tdata));
            return;
        end
        want = pending_commands.pop_front();
        if (m_tuser !== want.kind) begin
            report_mismatch($sformatf("kind %0d, predicted %0d", m_tuser, want.kind));
        end
        if (m_tdata !== want.duration_ms) begin
            report_mismatch($sformatf("duration %0d, predicted %0d",
                                      m_tdata, want.duration_ms));
        end
    endtask

    // Receiver: check transfers, then pick tready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_command();
        if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 4);
        $display("[tilt_gesture_mode_controller] ERROR");
        $finish;
    end

    initial begin
        int drain_cycles;
        drain_cycles = 0;
        apply_reset();
        test_choose_mode();
        // CHOOSE is left only once per reset, so each run takes one branch
        heater_branch = 1'($urandom_range(0, 1));
        if (heater_branch) begin
            test_heater_gestures();
        end else begin
            test_filter_gestures();
        end

        sender_idle_pct   = 30;
        receiver_idle_pct = 48;
        configure(15'($urandom_range(1000, 20000)), 16'($urandom_range(0, 8)),
                  $urandom, 16'($urandom_range(1, 65535)));
        test_random_gestures(180);
        configure(15'd0, 16'd0, 32'd0, 16'd0);
        test_random_gestures(180);

        sender_idle_pct   = 48;
        receiver_idle_pct = 30;
        configure(15'h7FFF, 16'd1, 32'hFFFF_FFFF, 16'hFFFF);
        test_random_gestures(180);
        configure(15'($urandom_range(0, 32767)), 16'($urandom_range(0, 15)),
                  $urandom, 16'($urandom));
        test_random_gestures(180);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_receiver_backpressure();
        configure(15'($urandom_range(500, 16000)), 16'($urandom_range(16, 40)),
                  $urandom, 16'($urandom));
        test_random_gestures(60);
        if (heater_branch) test_minute_saturation();

        // Drain the outstanding commands, bounded
        s_tvalid <= 1'b0;
        while (pending_commands.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (IDLE_CYCLES) @(posedge aclk);
        if (pending_commands.size() != 0) begin
            report_mismatch($sformatf("%0d predicted commands never arrived",
                                      pending_commands.size()));
        end
        if (error_count == 0) begin
            $display("[tilt_gesture_mode_controller] OK");
        end else begin
            $display("[tilt_gesture_mode_controller] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/tgmc_pkg.sv
rtl/tgmc_classify.sv
rtl/tilt_gesture_mode_controller.sv
tb/tb_top.sv
